// ===== design/lrps_pkg.sv =====
// ----------------------------------------------------------------------------
// lrps_pkg
// Shared types for the linear ramp parameter smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package lrps_pkg;

   // Operation carried by each input transaction.
   typedef enum logic [2:0] {
      MODE_TICK  = 3'd0,
      MODE_SET   = 3'd1,
      MODE_RAMP  = 3'd2,
      MODE_PEND  = 3'd3,
      MODE_CHECK = 3'd4,
      MODE_SKIP  = 3'd5
   } mode_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_MUL   = 3'd1,
      ST_SUM   = 3'd2,
      ST_EMIT  = 3'd3,
      ST_DIFF  = 3'd4,
      ST_DIV   = 3'd5,
      ST_SLOPE = 3'd6
   } state_type;

endpackage

`default_nettype wire

// ===== design/lrps_mul.sv =====
// ----------------------------------------------------------------------------
// lrps_mul
// Serial shift-and-add multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_mul #(
   parameter int A_WIDTH = 48,
   parameter int B_WIDTH = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [A_WIDTH-1:0]           mcand,
   input  wire logic [B_WIDTH-1:0]           mplier,
   output logic      [A_WIDTH+B_WIDTH-1:0]   product,
   output logic                              done
);

   localparam int CNTW = $clog2(B_WIDTH);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [A_WIDTH-1:0]  hi_ff, hi_in;
   logic [B_WIDTH-1:0]  lo_ff, lo_in;
   logic [A_WIDTH-1:0]  mcand_ff, mcand_in;
   logic [A_WIDTH:0]    part_sum;

   // The low half doubles as the multiplier shift register.
   assign part_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : {(A_WIDTH+1){1'b0}});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         hi_in    = '0;
         lo_in    = mplier;
         mcand_in = mcand;
      end else if (busy_ff) begin
         hi_in  = part_sum[A_WIDTH:1];
         lo_in  = {part_sum[0], lo_ff[B_WIDTH-1:1]};
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(B_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign product = {hi_ff, lo_ff};
   assign done    = done_ff;

endmodule

`default_nettype wire

// ===== design/lrps_div.sv =====
// ----------------------------------------------------------------------------
// lrps_div
// Serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_div #(
   parameter int DIVIDEND_WIDTH = 49,
   parameter int DIVISOR_WIDTH  = 20
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [DIVIDEND_WIDTH-1:0]   dividend,
   input  wire logic [DIVISOR_WIDTH-1:0]    divisor,
   output logic      [DIVIDEND_WIDTH-1:0]   quotient,
   output logic                             done
);

   localparam int CNTW = $clog2(DIVIDEND_WIDTH);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNTW-1:0]            cnt_ff, cnt_in;
   logic [DIVISOR_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [DIVIDEND_WIDTH-1:0]  quo_ff, quo_in;
   logic [DIVISOR_WIDTH:0]     trial;
   logic [DIVISOR_WIDTH:0]     trial_sub;
   logic                       fits;

   // The quotient register shifts the dividend out while quotient bits shift in.
   assign trial     = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(DIVIDEND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== design/linear_ramp_parameter_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// linear_ramp_parameter_smoother_unit
// Parameter de-zipper: immediate sets, linear ramps and sample generation.
// ----------------------------------------------------------------------------
// A tick transaction runs the bit-serial multiply of slope by samples remaining,
// then the sum and the emit state, which waits while a result is still held.
// A ramp start runs the multiply and sum, then the difference, the bit-serial
// slope divide and the slope load. Set, pending, skip and idle checks complete
// in the accepting cycle. One transaction is in flight at a time. Synchronous
// reset clears the control and architectural state, not the working values.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_ramp_parameter_smoother_unit #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 20
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [2:0]                     req_mode,
   input  wire logic signed [VALUE_WIDTH-1:0]  req_target_value,
   input  wire logic [COUNT_WIDTH-1:0]         req_duration,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]       rsp_sample,
   output logic                                rsp_ramping
);

   // The slope is Q32.16 and so carries 16 more fraction bits than a value.
   localparam int SW   = VALUE_WIDTH + 16;
   // The divide quotient: a difference below 2^VALUE_WIDTH shifted by 16.
   localparam int QW   = SW + 1;
   // Room for the goal plus the scaled product without wrapping.
   localparam int SUMW = VALUE_WIDTH + COUNT_WIDTH + 2;

   localparam logic [QW-1:0] SLOPE_LIM = {2'b01, {(SW-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Architectural state. The slope is held as sign and magnitude so that the
   // serial multiplier can work on an unsigned operand.
   lrps_pkg::state_type       state_ff, state_in;
   logic [VALUE_WIDTH-1:0]    goal_ff, goal_in;
   logic [VALUE_WIDTH-1:0]    last_ff, last_in;
   logic [SW-1:0]             slope_mag_ff, slope_mag_in;
   logic                      slope_neg_ff, slope_neg_in;
   logic [COUNT_WIDTH-1:0]    left_ff, left_in;
   logic                      pend_ff, pend_in;

   // Transaction in progress and working values.
   logic                      op_tick_ff, op_tick_in;
   logic [VALUE_WIDTH-1:0]    op_target_ff, op_target_in;
   logic [COUNT_WIDTH-1:0]    op_dur_ff, op_dur_in;
   logic [VALUE_WIDTH-1:0]    cur_ff, cur_in;
   logic                      neg_ff, neg_in;

   // Output register, which lets a new transaction be taken while a result waits.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                      rsp_ramping_ff, rsp_ramping_in;

   lrps_pkg::mode_type        req_mode_e;
   logic                      accept;
   logic                      need_mul;
   logic                      out_free;
   logic                      mul_start, mul_done, sum_load, div_start, div_done;
   logic                      slope_load, emit;
   logic [SW+COUNT_WIDTH-1:0] product;
   logic [QW-1:0]             quotient;

   logic [SUMW-1:0]           scaled;
   logic [SUMW-1:0]           goal_ext;
   logic [SUMW-1:0]           sum_wide;
   logic                      sum_ovf;
   logic [VALUE_WIDTH-1:0]    sum_sat;

   logic [VALUE_WIDTH:0]      diff;
   logic [VALUE_WIDTH:0]      diff_mag;
   logic [QW-1:0]             q_sat;

   assign req_mode_e = lrps_pkg::mode_type'(req_mode);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // A tick always runs the multiply: with no ramp left, or a zero slope, the
   // product is zero and the sample falls back to the goal level by itself.
   always_comb begin
      case (req_mode_e)
         lrps_pkg::MODE_TICK:  need_mul = 1'b1;
         lrps_pkg::MODE_RAMP:  need_mul = (req_duration != '0);
         lrps_pkg::MODE_CHECK: need_mul = pend_ff && (req_duration != '0);
         default:              need_mul = 1'b0;
      endcase
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrps_pkg::ST_IDLE:  if (accept && need_mul) state_in = lrps_pkg::ST_MUL;
         lrps_pkg::ST_MUL:   if (mul_done) state_in = lrps_pkg::ST_SUM;
         lrps_pkg::ST_SUM:   state_in = op_tick_ff ? lrps_pkg::ST_EMIT : lrps_pkg::ST_DIFF;
         lrps_pkg::ST_EMIT:  if (out_free) state_in = lrps_pkg::ST_IDLE;
         lrps_pkg::ST_DIFF:  state_in = lrps_pkg::ST_DIV;
         lrps_pkg::ST_DIV:   if (div_done) state_in = lrps_pkg::ST_SLOPE;
         lrps_pkg::ST_SLOPE: state_in = lrps_pkg::ST_IDLE;
         default:            state_in = lrps_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready  = 1'b0;
      sum_load   = 1'b0;
      div_start  = 1'b0;
      slope_load = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         lrps_pkg::ST_IDLE:  req_ready  = 1'b1;
         lrps_pkg::ST_SUM:   sum_load   = 1'b1;
         lrps_pkg::ST_EMIT:  emit       = out_free;
         lrps_pkg::ST_DIFF:  div_start  = 1'b1;
         lrps_pkg::ST_SLOPE: slope_load = 1'b1;
         default:            ;
      endcase
   end

   assign mul_start = accept && need_mul;

   // Present sample: the product carries 16 extra fraction bits, which are
   // dropped, so the magnitude is truncated before the sign is applied.
   assign scaled   = {2'b00, product[SW+COUNT_WIDTH-1:16]};
   assign goal_ext = {{(COUNT_WIDTH+2){goal_ff[VALUE_WIDTH-1]}}, goal_ff};
   assign sum_wide = slope_neg_ff ? (goal_ext - scaled) : (goal_ext + scaled);
   assign sum_ovf  = !((&sum_wide[SUMW-1:VALUE_WIDTH-1]) || !(|sum_wide[SUMW-1:VALUE_WIDTH-1]));
   assign sum_sat  = sum_ovf ? (sum_wide[SUMW-1] ? VAL_MIN : VAL_MAX)
                             : sum_wide[VALUE_WIDTH-1:0];

   // Ramp difference from the present sample down to the target.
   assign diff     = {cur_ff[VALUE_WIDTH-1], cur_ff}
                   - {op_target_ff[VALUE_WIDTH-1], op_target_ff};
   assign diff_mag = diff[VALUE_WIDTH] ? (~diff + 1'b1) : diff;

   // The slope magnitude saturates at 2^(SW-1) when negative and one below
   // that when positive.
   always_comb begin
      q_sat = (quotient > SLOPE_LIM) ? SLOPE_LIM : quotient;
      if (!neg_ff && (q_sat == SLOPE_LIM)) begin
         q_sat = SLOPE_LIM - 1'b1;
      end
   end

   // Datapath next values.
   always_comb begin
      goal_in        = goal_ff;
      last_in        = last_ff;
      slope_mag_in   = slope_mag_ff;
      slope_neg_in   = slope_neg_ff;
      left_in        = left_ff;
      pend_in        = pend_ff;
      op_tick_in     = op_tick_ff;
      op_target_in   = op_target_ff;
      op_dur_in      = op_dur_ff;
      cur_in         = cur_ff;
      neg_in         = neg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_ramping_in = rsp_ramping_ff;

      if (accept) begin
         op_tick_in   = (req_mode_e == lrps_pkg::MODE_TICK);
         op_target_in = req_target_value;
         op_dur_in    = req_duration;
         case (req_mode_e)
            lrps_pkg::MODE_SET: begin
               goal_in      = req_target_value;
               last_in      = req_target_value;
               slope_mag_in = '0;
               slope_neg_in = 1'b0;
               left_in      = '0;
            end
            lrps_pkg::MODE_RAMP: begin
               last_in = req_target_value;
               // A ramp of no length is an immediate set.
               if (req_duration == '0) begin
                  goal_in      = req_target_value;
                  slope_mag_in = '0;
                  slope_neg_in = 1'b0;
                  left_in      = '0;
               end
            end
            lrps_pkg::MODE_PEND: begin
               if (last_ff != req_target_value) begin
                  last_in = req_target_value;
                  pend_in = 1'b1;
               end
            end
            lrps_pkg::MODE_CHECK: begin
               if (pend_ff) begin
                  pend_in      = 1'b0;
                  op_target_in = last_ff;
                  if (req_duration == '0) begin
                     goal_in      = last_ff;
                     slope_mag_in = '0;
                     slope_neg_in = 1'b0;
                     left_in      = '0;
                  end
               end
            end
            lrps_pkg::MODE_SKIP: begin
               left_in = (req_duration >= left_ff) ? '0 : (left_ff - req_duration);
            end
            default: ;
         endcase
      end

      if (sum_load) begin
         cur_in = sum_sat;
      end

      if (div_start) begin
         neg_in = diff[VALUE_WIDTH];
      end

      if (slope_load) begin
         slope_mag_in = q_sat[SW-1:0];
         slope_neg_in = neg_ff;
         left_in      = op_dur_ff;
         goal_in      = op_target_ff;
      end

      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_sample_in  = cur_ff;
         rsp_ramping_in = (left_ff != '0);
         if (left_ff != '0) begin
            left_in = left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrps_pkg::ST_IDLE;
         goal_ff      <= '0;
         last_ff      <= '0;
         slope_mag_ff <= '0;
         slope_neg_ff <= 1'b0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         goal_ff      <= goal_in;
         last_ff      <= last_in;
         slope_mag_ff <= slope_mag_in;
         slope_neg_ff <= slope_neg_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_tick_ff     <= op_tick_in;
      op_target_ff   <= op_target_in;
      op_dur_ff      <= op_dur_in;
      cur_ff         <= cur_in;
      neg_ff         <= neg_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_ramping_ff <= rsp_ramping_in;
   end

   // Slope times samples remaining, one bit of the count per cycle.
   lrps_mul #(
      .A_WIDTH (SW),
      .B_WIDTH (COUNT_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (slope_mag_ff),
      .mplier  (left_ff),
      .product (product),
      .done    (mul_done)
   );

   // Difference magnitude scaled by 2^16 over the ramp length.
   lrps_div #(
      .DIVIDEND_WIDTH (QW),
      .DIVISOR_WIDTH  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({diff_mag, 16'd0}),
      .divisor  (op_dur_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = rsp_sample_ff;
   assign rsp_ramping = rsp_ramping_ff;

   // The multiplier only finishes while the sequencer waits for it.
   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == lrps_pkg::ST_MUL))
      else $error("multiplier finished outside its wait state");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lrps_pkg::ST_DIV))
      else $error("divider finished outside its wait state");

   // A positive slope never reaches 2^(SW-1); a negative one never exceeds it.
   a_slope_range: assert property (@(posedge clock) disable iff (reset)
      !(slope_mag_ff[SW-1] && (!slope_neg_ff || (|slope_mag_ff[SW-2:0]))))
      else $error("slope magnitude outside its saturated range");

   // A result released from the emit state is presented in the next cycle.
   a_emit_presents: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid && (state_ff == lrps_pkg::ST_IDLE)))
      else $error("emitted result not presented");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear ramp parameter smoother.
// ----------------------------------------------------------------------------
// A short scripted opening covers the value extremes, every mode, saturated
// slopes, zero-length ramps, flat ramps and skip saturation. A long random
// phase of mostly ramp-and-tick traffic follows. An in-bench model of the
// smoother predicts every tick result. Both handshakes stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 20;

   // Random transactions after the scripted opening; about 500 in all.
   localparam int RANDOM_TRANSACTIONS = 470;
   // Worst case per transaction is a ramp start, the longest sender gap and the
   // longest receiver stall. Summed over about 500 transactions, that stays well
   // inside this limit.
   localparam int CYCLE_LIMIT = 500_000;
   // Covers the time that a ramp start keeps the block busy after acceptance.
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_PRINTED = 50;

   // The two mode codes that the package leaves unnamed.
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   localparam longint SAMPLE_MAX = 64'sh7FFF_FFFF;
   localparam longint SAMPLE_MIN = -64'sh8000_0000;
   // Magnitude bound of the Q32.16 slope held in VALUE_WIDTH + 16 bits.
   localparam bit [63:0] SLOPE_LIMIT = 64'h0000_8000_0000_0000;

   typedef struct {
      logic [VALUE_WIDTH-1:0] sample;
      logic                   ramping;
   } tick_result_type;

   typedef struct {
      logic [2:0]             mode;
      logic [VALUE_WIDTH-1:0] target;
      logic [COUNT_WIDTH-1:0] duration;
      bit                     typed;
      logic [VALUE_WIDTH-1:0] sample;
      logic                   ramping;
   } script_row_type;

   // ---------------------------------------------------------------------
   // Signals of the block. Every input holds a known value from time zero.
   // ---------------------------------------------------------------------
   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [2:0]                    req_mode = lrps_pkg::MODE_TICK;
   logic signed [VALUE_WIDTH-1:0] req_target_value = '0;
   logic [COUNT_WIDTH-1:0]        req_duration = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_sample;
   logic                          rsp_ramping;

   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              rsp_hold = 0;
   tick_result_type awaited_ticks[$];
   script_row_type  opening_script[$];

   // Both sides run without any idling for part of each counter period, so that
   // back-to-back traffic is exercised as well as the stalled kind.
   wire quiet_stretch = (cycle_count % 4096) < 600;

   linear_ramp_parameter_smoother_unit #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_target_value (req_target_value),
      .req_duration     (req_duration),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_ramping      (rsp_ramping)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Smoother model. Its state starts out as the block's state after reset.
   // Levels are held sign-extended in 64 bits so that no intermediate sum
   // can overflow before it is saturated.
   // ---------------------------------------------------------------------
   longint    level_goal = 0;
   longint    level_last_target = 0;
   longint    level_slope = 0;
   bit [63:0] level_left = 0;
   bit        level_pending = 1'b0;

   function automatic longint clamp_level(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // The present output: slope times samples remaining, shifted down by 16
   // with the magnitude truncated, plus the goal, saturated.
   function automatic longint ramp_value();
      bit [63:0] mag, hi, lo, t;
      bit        neg;
      if (level_left == 0 || level_slope == 0) return level_goal;
      neg = level_slope < 0;
      mag = neg ? -level_slope : level_slope;
      hi  = (mag >> 32) * level_left;
      lo  = (mag & 64'hFFFF_FFFF) * level_left;
      if (hi >= (64'd1 << 46)) return neg ? SAMPLE_MIN : SAMPLE_MAX;
      t = (hi << 16) + (lo >> 16);
      if (t > (64'd1 << 61)) t = 64'd1 << 61;
      return clamp_level(neg ? level_goal - longint'(t) : level_goal + longint'(t));
   endfunction

   function automatic void settle_level(input longint target);
      level_goal        = target;
      level_last_target = target;
      level_slope       = 0;
      level_left        = 0;
   endfunction

   // The slope is the distance still to cover, in Q32.16, over the ramp
   // length, truncated toward zero and saturated to the slope register.
   function automatic void launch_ramp(input longint target, input bit [63:0] n);
      longint    cur, diff;
      bit [63:0] mag, qh, r, q;
      bit        neg;
      cur = ramp_value();
      level_last_target = target;
      if (n == 0) begin
         settle_level(target);
         return;
      end
      diff = cur - target;
      neg  = diff < 0;
      mag  = neg ? -diff : diff;
      qh   = mag / n;
      r    = mag % n;
      if (qh >= (64'd1 << (VALUE_WIDTH - 1))) q = SLOPE_LIMIT;
      else q = (qh << 16) + ((r << 16) / n);
      if (q > SLOPE_LIMIT) q = SLOPE_LIMIT;
      if (!neg && q > SLOPE_LIMIT - 1) q = SLOPE_LIMIT - 1;
      level_slope = neg ? -longint'(q) : longint'(q);
      level_left  = n;
      level_goal  = target;
   endfunction

   // Applies one accepted transaction. Only a tick gives a result.
   function automatic void advance_smoother(input logic [2:0] mode,
                                            input logic signed [VALUE_WIDTH-1:0] target,
                                            input logic [COUNT_WIDTH-1:0] duration,
                                            output bit emits,
                                            output tick_result_type result);
      longint    tgt, s;
      bit [63:0] n;
      tgt            = target;
      n              = 64'(duration);
      emits          = 1'b0;
      result.sample  = '0;
      result.ramping = 1'b0;
      case (mode)
         lrps_pkg::MODE_TICK: begin
            emits = 1'b1;
            if (level_left != 0) begin
               s = ramp_value();
               level_left--;
               result.ramping = 1'b1;
            end else begin
               s = level_goal;
            end
            result.sample = s[VALUE_WIDTH-1:0];
         end
         lrps_pkg::MODE_SET: settle_level(tgt);
         lrps_pkg::MODE_RAMP: launch_ramp(tgt, n);
         lrps_pkg::MODE_PEND: begin
            if (level_last_target != tgt) begin
               level_last_target = tgt;
               level_pending     = 1'b1;
            end
         end
         lrps_pkg::MODE_CHECK: begin
            if (level_pending) begin
               level_pending = 1'b0;
               launch_ramp(level_last_target, n);
            end
         end
         lrps_pkg::MODE_SKIP: level_left = (n >= level_left) ? 64'd0 : level_left - n;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Idling: mostly none, sometimes a short gap, now and then a long pause.
   // ---------------------------------------------------------------------
   function automatic int idle_gap();
      int pick;
      if (quiet_stretch) return 0;
      pick = $urandom_range(99);
      if (pick < 60) return 0;
      if (pick < 88) return $urandom_range(3, 1);
      if (pick < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      // Keep the log readable if the block is badly broken; all are counted.
      if (mismatch_count <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
   endtask

   // Offers one transaction, waits for it to be taken and records what the
   // model says it should produce. Where the script gives the result by
   // hand, that value is awaited instead, though the model still advances.
   task automatic drive_transaction(input logic [2:0] mode,
                                    input logic [VALUE_WIDTH-1:0] target,
                                    input logic [COUNT_WIDTH-1:0] duration,
                                    input bit typed,
                                    input logic [VALUE_WIDTH-1:0] want_sample,
                                    input logic want_ramping);
      int              gap;
      bit              emits;
      tick_result_type predicted;
      gap = idle_gap();
      // Valid is only lowered when a real gap follows, so it is never
      // dropped and raised again within one time step.
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_target_value <= target;
      req_duration     <= duration;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_smoother(mode, target, duration, emits, predicted);
      if (emits) begin
         if (typed) begin
            predicted.sample  = want_sample;
            predicted.ramping = want_ramping;
         end
         awaited_ticks.push_back(predicted);
      end
   endtask

   function automatic void add_row(input logic [2:0] mode,
                                   input logic [VALUE_WIDTH-1:0] target,
                                   input logic [COUNT_WIDTH-1:0] duration,
                                   input bit typed,
                                   input logic [VALUE_WIDTH-1:0] sample,
                                   input logic ramping);
      script_row_type row;
      row.mode     = mode;
      row.target   = target;
      row.duration = duration;
      row.typed    = typed;
      row.sample   = sample;
      row.ramping  = ramping;
      opening_script.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and the comparison against the
   // oldest awaited tick result. Signals are read at the clock edge, so the
   // values seen are those from before the edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_ticks.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited: sample %h ramping %b",
                                      rsp_sample, rsp_ramping));
         end else begin
            want = awaited_ticks.pop_front();
            if (rsp_sample !== want.sample)
               report_mismatch($sformatf("sample %h, expected %h", rsp_sample, want.sample));
            if (rsp_ramping !== want.ramping)
               report_mismatch($sformatf("ramping %b, expected %b (sample %h)",
                                         rsp_ramping, want.ramping, want.sample));
         end
      end
      if (rsp_hold != 0) begin
         rsp_hold  = rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold  = idle_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   initial begin
      int                     sent;
      int                     pick;
      logic [2:0]             mode;
      logic [VALUE_WIDTH-1:0] target;
      logic [COUNT_WIDTH-1:0] duration;

      // Straight out of reset the output is zero and nothing is ramping.
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b1, 32'h0, 1'b0);
      // Immediate sets to both extremes of the value range.
      add_row(lrps_pkg::MODE_SET, 32'h7FFF_FFFF, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'hF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0);
      add_row(lrps_pkg::MODE_SET, 32'h8000_0000, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'hFFFF_FFFF, 20'h0, 1'b1, 32'h8000_0000, 1'b0);
      // A full-scale rise in one sample: the slope saturates negative.
      add_row(lrps_pkg::MODE_RAMP, 32'h7FFF_FFFF, 20'd1, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b1, 32'h7FFF_FFFF, 1'b0);
      // A full-scale fall in one sample: the slope saturates positive.
      add_row(lrps_pkg::MODE_RAMP, 32'h8000_0000, 20'd1, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b0, 32'h0, 1'b0);
      // The longest ramp, then a skip that leaves exactly one sample.
      add_row(lrps_pkg::MODE_RAMP, 32'h0, 20'hF_FFFF, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_SKIP, 32'h0, 20'hF_FFFD, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b1, 32'h0, 1'b0);
      // A ramp of zero length behaves as an immediate set.
      add_row(lrps_pkg::MODE_RAMP, 32'h0001_0000, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b1, 32'h0001_0000, 1'b0);
      // A ramp to the present value has a flat slope but still counts down.
      add_row(lrps_pkg::MODE_RAMP, 32'h0001_0000, 20'd2, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b1, 32'h0001_0000, 1'b1);
      // An unchanged pending target leaves the check with nothing to do.
      add_row(lrps_pkg::MODE_PEND, 32'h0001_0000, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_CHECK, 32'h0, 20'd4, 1'b0, 32'h0, 1'b0);
      // An oversized skip saturates the count at zero.
      add_row(lrps_pkg::MODE_SKIP, 32'h0, 20'hF_FFFF, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b1, 32'h0001_0000, 1'b0);
      // A changed pending target is ramped to by the next check.
      add_row(lrps_pkg::MODE_PEND, 32'hFFFF_0000, 20'h0, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_CHECK, 32'h0, 20'd4, 1'b0, 32'h0, 1'b0);
      // The unused mode codes must not disturb the ramp under way.
      add_row(MODE_SPARE_A, 32'h1234_5678, 20'd5, 1'b0, 32'h0, 1'b0);
      add_row(MODE_SPARE_B, 32'hEDCB_A987, 20'hA_5A5A, 1'b0, 32'h0, 1'b0);
      add_row(lrps_pkg::MODE_TICK, 32'h0, 20'h0, 1'b0, 32'h0, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_script[i])
         drive_transaction(opening_script[i].mode, opening_script[i].target,
                           opening_script[i].duration, opening_script[i].typed,
                           opening_script[i].sample, opening_script[i].ramping);

      // Random phase. Ticks dominate so that ramps are followed through;
      // targets often repeat the last one or sit close to the goal so that
      // the pending and flat-slope paths are hit, and most ramps are short.
      sent = 0;
      while (sent < RANDOM_TRANSACTIONS) begin
         pick = $urandom_range(99);
         if (pick < 45) mode = lrps_pkg::MODE_TICK;
         else if (pick < 51) mode = lrps_pkg::MODE_SET;
         else if (pick < 65) mode = lrps_pkg::MODE_RAMP;
         else if (pick < 77) mode = lrps_pkg::MODE_PEND;
         else if (pick < 89) mode = lrps_pkg::MODE_CHECK;
         else if (pick < 96) mode = lrps_pkg::MODE_SKIP;
         else mode = ($urandom_range(1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;

         pick = $urandom_range(99);
         if (pick < 30) begin
            target = level_last_target[VALUE_WIDTH-1:0];
         end else if (pick < 40) begin
            case ($urandom_range(2))
               0: target = 32'h7FFF_FFFF;
               1: target = 32'h8000_0000;
               default: target = '0;
            endcase
         end else if (pick < 60) begin
            target = level_goal[VALUE_WIDTH-1:0] + $urandom_range(2000) - 1000;
         end else begin
            target = $urandom;
         end

         pick = $urandom_range(99);
         if (mode == lrps_pkg::MODE_SKIP) begin
            if (pick < 20) duration = '0;
            else if (pick < 70) duration = COUNT_WIDTH'($urandom_range(8, 1));
            else if (pick < 90) duration = COUNT_WIDTH'($urandom_range(100, 9));
            else duration = COUNT_WIDTH'($urandom_range(20'hF_FFFF));
         end else begin
            if (pick < 10) duration = '0;
            else if (pick < 70) duration = COUNT_WIDTH'($urandom_range(24, 1));
            else if (pick < 90) duration = COUNT_WIDTH'($urandom_range(300, 25));
            else if (pick < 97) duration = COUNT_WIDTH'($urandom_range(20'hF_FFFF));
            else duration = 20'hF_FFFF;
         end

         drive_transaction(mode, target, duration, 1'b0, '0, 1'b0);
         sent++;
      end
      req_valid <= 1'b0;

      // Let the outstanding tick results arrive, then give a late or extra
      // result time to show itself.
      while (awaited_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
